### rtl/hex_text_to_ubx_frame_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex text to frame encoder
// Include-guarded macros that wrap concurrent assertions on clk_i/rst_ni.
// ----------------------------------------------------------------------------
`ifndef HEX_TEXT_TO_UBX_FRAME_MACROS_SVH
`define HEX_TEXT_TO_UBX_FRAME_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property outside of reset.
`define HTU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Check a property at every edge, reset included.
`define HTU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define HTU_ASSERT(label, prop)
`define HTU_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/hexubx_pkg.sv
// ----------------------------------------------------------------------------
// hexubx_pkg
// Shared types and constants of the hex text to frame encoder.
// ----------------------------------------------------------------------------
package hexubx_pkg;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [16:0] LEN_BIAS = 17'd4;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Status codes of a result word
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MINUS  = 3'd1;
  localparam logic [2:0] ST_BAD_HIGH  = 3'd2;
  localparam logic [2:0] ST_BAD_LOW   = 3'd3;
  localparam logic [2:0] ST_LEN_ERR   = 3'd4;

  // Parser modes, one-hot
  typedef enum logic [6:0] {
    MODE_LABEL = 7'b0000001,
    MODE_MINUS = 7'b0000010,
    MODE_FIELD = 7'b0000100,
    MODE_HIGH  = 7'b0001000,
    MODE_LOW   = 7'b0010000,
    MODE_SEP   = 7'b0100000,
    MODE_HALT  = 7'b1000000
  } mode_e;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_last;
    logic [2:0] status;
  } res_t;

  // Up to two result words produced by one accepted input word
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Decode an ASCII hex digit: bit 4 = valid, bits 3:0 = value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

### rtl/hexubx_parse.sv
// ----------------------------------------------------------------------------
// hexubx_parse
// Record parser: mode update, byte assembly and Fletcher sums per input word.
// ----------------------------------------------------------------------------
`include "hex_text_to_ubx_frame_macros.svh"

module hexubx_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         char_i,
  input  logic               eot_i,
  output hexubx_pkg::push_t  push_o
);
  import hexubx_pkg::*;

  mode_e       mode_q, mode_d;
  logic [3:0]  high_q, high_d;
  logic [16:0] count_q, count_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  push_t       push;
  logic [4:0]  hv;
  logic [7:0]  b;
  logic [7:0]  sa_next;

  assign hv      = hex_value(char_i);
  assign b       = {high_q, hv[3:0]};
  assign sa_next = sum_a_q + b;

  // Decode one word against the current mode
  always_comb begin
    mode_d  = mode_q;
    high_d  = high_q;
    count_d = count_q;
    len_d   = len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    push    = '0;
    case (mode_q)
      MODE_LABEL: begin
        if (!eot_i && char_i == CH_BLANK) mode_d = MODE_MINUS;
      end
      MODE_MINUS: begin
        if (eot_i) begin
          mode_d = MODE_LABEL;
        end else if (char_i != CH_MINUS) begin
          push.n = 2'd1;
          push.r0 = '{out_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b1,
                      status: ST_NO_MINUS};
          mode_d = MODE_HALT;
        end else begin
          mode_d = MODE_FIELD;
        end
      end
      MODE_FIELD: begin
        if (eot_i) begin
          mode_d = MODE_LABEL;
        end else if (char_i == CH_BLANK) begin
          count_d = '0;
          len_d   = '0;
          sum_a_d = '0;
          sum_b_d = '0;
          mode_d  = MODE_HIGH;
          push.n  = 2'd2;
          push.r0 = '{out_byte: SYNC_ONE, byte_valid: 1'b1, frame_last: 1'b0,
                      status: ST_OK};
          push.r1 = '{out_byte: SYNC_TWO, byte_valid: 1'b1, frame_last: 1'b0,
                      status: ST_OK};
        end
      end
      MODE_HIGH: begin
        if (eot_i || !hv[4]) begin
          push.n = 2'd1;
          push.r0 = '{out_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b1,
                      status: ST_BAD_HIGH};
          mode_d = MODE_HALT;
        end else begin
          high_d = hv[3:0];
          mode_d = MODE_LOW;
        end
      end
      MODE_LOW: begin
        if (eot_i || !hv[4]) begin
          push.n = 2'd1;
          push.r0 = '{out_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b1,
                      status: ST_BAD_LOW};
          mode_d = MODE_HALT;
        end else begin
          if (count_q == 17'd2) len_d = {len_q[15:8], b};
          if (count_q == 17'd3) len_d = {b, len_q[7:0]};
          if (count_q != COUNT_MAX) count_d = count_q + 17'd1;
          sum_a_d = sa_next;
          sum_b_d = sum_b_q + sa_next;
          mode_d  = MODE_SEP;
          push.n  = 2'd1;
          push.r0 = '{out_byte: b, byte_valid: 1'b1, frame_last: 1'b0,
                      status: ST_OK};
        end
      end
      MODE_SEP: begin
        if (!eot_i && char_i == CH_BLANK) begin
          mode_d = MODE_HIGH;
        end else if ({1'b0, len_q} + LEN_BIAS != count_q) begin
          push.n = 2'd1;
          push.r0 = '{out_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b1,
                      status: ST_LEN_ERR};
          mode_d = MODE_HALT;
        end else begin
          mode_d  = MODE_LABEL;
          push.n  = 2'd2;
          push.r0 = '{out_byte: sum_a_q, byte_valid: 1'b1, frame_last: 1'b0,
                      status: ST_OK};
          push.r1 = '{out_byte: sum_b_q, byte_valid: 1'b1, frame_last: 1'b1,
                      status: ST_OK};
        end
      end
      MODE_HALT: begin
        mode_d = MODE_HALT;
      end
      default: begin
        mode_d = MODE_HALT;
      end
    endcase
  end

  // Hand results on only for an accepted word
  always_comb begin
    push_o = push;
    if (!take_i) push_o.n = 2'd0;
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LABEL;
      high_q  <= '0;
      count_q <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      high_q  <= high_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  `HTU_ASSERT(a_halt_sticky, mode_q == MODE_HALT |=> mode_q == MODE_HALT)
  `HTU_ASSERT(a_err_halts,
              take_i && push.n != 2'd0 && push.r0.status != ST_OK |=> mode_q == MODE_HALT)
  `HTU_ASSERT(a_err_is_last,
              push_o.n != 2'd0 && push_o.r0.status != ST_OK |-> push_o.r0.frame_last && push_o.n == 2'd1)

endmodule

### rtl/hexubx_fifo.sv
// ----------------------------------------------------------------------------
// hexubx_fifo
// Four-entry result queue: takes up to two words in, hands one word out.
// ----------------------------------------------------------------------------
`include "hex_text_to_ubx_frame_macros.svh"

module hexubx_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hexubx_pkg::push_t push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hexubx_pkg::res_t  data_o
);
  import hexubx_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + push_i.n;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.n} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed words in order
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

  `HTU_ASSERT(a_cnt_bound, cnt_q <= 3'd4)
  `HTU_ASSERT(a_no_overflow, push_i.n != 2'd0 |-> cnt_q + 3'(push_i.n) <= 3'd4)
  `HTU_ASSERT(a_ptr_track, wr_q == rd_q + cnt_q[1:0])

endmodule

### rtl/hex_text_to_ubx_frame.sv
// ----------------------------------------------------------------------------
// hex_text_to_ubx_frame
// Turns a configuration text, one character per word, into binary frames
// with sync bytes, message bytes and a Fletcher-8 checksum pair.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser                     | tlast
//  s_axis   | in  | text_char[7:0] | [0] end_of_text           | -
//  m_axis   | out | out_byte[7:0]  | [0] byte_valid,[3:1] status | frame_last
//
//  An input word is parsed in the cycle it is accepted; its zero to two
//  result words land in a four-entry queue and leave one per cycle while
//  the receiver is ready. Words with no result are taken every cycle while
//  the queue has room; s_axis_tready drops while fewer than two entries are
//  free, so the output port bounds the rate to one result word per cycle.
//  Reset clears the parser to label scanning and empties the queue.
//  After an error word the parser halts and emits nothing until reset.
// ----------------------------------------------------------------------------
module hex_text_to_ubx_frame (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  logic [0:0] s_axis_tuser,   // [0] end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser,   // [0] byte_valid, [3:1] status
  output logic       m_axis_tlast    // frame_last
);
  import hexubx_pkg::*;

  logic  take;
  logic  room;
  push_t push;
  res_t  res;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  // Parse accepted words
  hexubx_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (s_axis_tdata),
    .eot_i  (s_axis_tuser[0]),
    .push_o (push)
  );

  // Queue result words toward the output
  hexubx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tuser = {res.status, res.byte_valid};
  assign m_axis_tlast = res.frame_last;

endmodule

### tb/hex_text_to_ubx_frame_test.sv
// ----------------------------------------------------------------------------
// hex_text_to_ubx_frame_test
// Self-checking bench for the hex text to frame encoder. Streams record text
// (labels, option fields, hex byte lists with correct length fields) into
// s_axis, predicts sync, message and checksum words in a scoreboard, and
// compares every m_axis word. Since an error halts the encoder until reset,
// each run closes with one randomly chosen record kind (good or one of the
// four faults) and then a few words that must produce nothing after a fault.
// ----------------------------------------------------------------------------
module hex_text_to_ubx_frame_test;
  import hexubx_pkg::*;

  localparam int BODY_TARGET = 210;   // hex-field words for the random part

  // Scoreboard: mirror of the parser plus the queue of expected words
  class frame_book;
    mode_e       mode;
    logic [3:0]  hi_nib;
    logic [16:0] n_bytes;
    logic [15:0] len_fld;
    logic [7:0]  fa;
    logic [7:0]  fb;
    res_t        pending[$];
    int unsigned n_err;
    int unsigned n_words_in;
    int unsigned n_words_out;
    int unsigned n_frames;

    function new();
      mode = MODE_LABEL;
      hi_nib = '0;
      n_bytes = '0;
      len_fld = '0;
      fa = '0;
      fb = '0;
      n_err = 0;
      n_words_in = 0;
      n_words_out = 0;
      n_frames = 0;
    endfunction

    // Decode an ASCII hex digit, -1 when it is not one
    static function int nibble_of(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch - "0");
      if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
      if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
      return -1;
    endfunction

    function void push_word(logic [7:0] b, logic v, logic last, logic [2:0] st);
      res_t w;
      w.out_byte = b;
      w.byte_valid = v;
      w.frame_last = last;
      w.status = st;
      pending.push_back(w);
    endfunction

    function void halt_with(logic [2:0] st);
      push_word(8'h00, 1'b0, 1'b1, st);
      mode = MODE_HALT;
    endfunction

    // Advance the parser by one accepted text word
    function void note_input(logic [7:0] ch, logic eot);
      int nib;
      logic [7:0] val;
      n_words_in++;
      nib = eot ? -1 : nibble_of(ch);
      case (mode)
        MODE_LABEL: begin
          if (!eot && ch == CH_BLANK) mode = MODE_MINUS;
        end
        MODE_MINUS: begin
          if (eot) mode = MODE_LABEL;
          else if (ch != CH_MINUS) halt_with(ST_NO_MINUS);
          else mode = MODE_FIELD;
        end
        MODE_FIELD: begin
          if (eot) begin
            mode = MODE_LABEL;
          end else if (ch == CH_BLANK) begin
            n_bytes = '0;
            len_fld = '0;
            fa = '0;
            fb = '0;
            mode = MODE_HIGH;
            push_word(SYNC_ONE, 1'b1, 1'b0, ST_OK);
            push_word(SYNC_TWO, 1'b1, 1'b0, ST_OK);
          end
        end
        MODE_HIGH: begin
          if (nib < 0) begin
            halt_with(ST_BAD_HIGH);
          end else begin
            hi_nib = nib[3:0];
            mode = MODE_LOW;
          end
        end
        MODE_LOW: begin
          if (nib < 0) begin
            halt_with(ST_BAD_LOW);
          end else begin
            val = {hi_nib, nib[3:0]};
            if (n_bytes == 17'd2) len_fld[7:0] = val;
            if (n_bytes == 17'd3) len_fld[15:8] = val;
            if (n_bytes != COUNT_MAX) n_bytes = n_bytes + 17'd1;
            fa = fa + val;
            fb = fb + fa;
            mode = MODE_SEP;
            push_word(val, 1'b1, 1'b0, ST_OK);
          end
        end
        MODE_SEP: begin
          if (!eot && ch == CH_BLANK) begin
            mode = MODE_HIGH;
          end else if ({1'b0, len_fld} + LEN_BIAS != n_bytes) begin
            halt_with(ST_LEN_ERR);
          end else begin
            mode = MODE_LABEL;
            push_word(fa, 1'b1, 1'b0, ST_OK);
            push_word(fb, 1'b1, 1'b1, ST_OK);
          end
        end
        default: mode = MODE_HALT;
      endcase
    endfunction

    task report(string msg);
      n_err++;
      if (n_err <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compare one output word with the oldest expectation
    task check_result(res_t got);
      res_t want;
      n_words_out++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word byte=%02h valid=%0b last=%0b status=%0d",
                         got.out_byte, got.byte_valid, got.frame_last, got.status));
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.frame_last !== want.frame_last || got.status !== want.status) begin
        report($sformatf("got byte=%02h valid=%0b last=%0b status=%0d, want %02h %0b %0b %0d",
                         got.out_byte, got.byte_valid, got.frame_last, got.status,
                         want.out_byte, want.byte_valid, want.frame_last, want.status));
      end else if (got.frame_last && got.status == ST_OK) begin
        n_frames++;
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_char
  logic [0:0] s_axis_tuser = 1'b0;    // [0] end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [3:0] m_axis_tuser;           // [0] byte_valid, [3:1] status
  logic       m_axis_tlast;           // frame_last

  frame_book   book = new();
  int unsigned src_idle_pct = 30;
  int unsigned snk_stall_pct = 47;
  int unsigned body_words = 0;
  logic [2:0]  closing_st;

  hex_text_to_ubx_frame dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Stall the receiver at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Check every word leaving the encoder
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      book.check_result('{out_byte: m_axis_tdata, byte_valid: m_axis_tuser[0],
                          frame_last: m_axis_tlast, status: m_axis_tuser[3:1]});
    end
  end

  // Offer one text word; called and left at a falling edge
  task automatic send_word(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= eot;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    book.note_input(ch, eot);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] skip);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == skip) c = c ^ 8'h01;
    return c;
  endfunction

  // Pick a digit character, letters in either case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    if ($urandom_range(1)) return 8'h41 + (v - 4'd10);
    return 8'h61 + (v - 4'd10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_word(hex_char(b[7:4]), 1'b0);
    send_word(hex_char(b[3:0]), 1'b0);
    body_words += 2;
  endtask

  task automatic send_label();
    repeat ($urandom_range(1, 6)) send_word(any_but(CH_BLANK), 1'b0);
  endtask

  // Label, blank, minus, option field, blank: opens the hex field
  task automatic send_head();
    send_label();
    send_word(CH_BLANK, 1'b0);
    send_word(CH_MINUS, 1'b0);
    repeat ($urandom_range(0, 3)) send_word(any_but(CH_BLANK), 1'b0);
    send_word(CH_BLANK, 1'b0);
  endtask

  task automatic send_bytes(input int unsigned count, input logic [15:0] len);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i != 0) send_word(CH_BLANK, 1'b0);
      b = (i == 2) ? len[7:0] : (i == 3) ? len[15:8] : 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  task automatic send_frame(input int unsigned count, input logic [15:0] len,
                            input bit end_eot);
    send_head();
    send_bytes(count, len);
    if (end_eot) send_word(8'($urandom_range(255)), 1'b1);
    else send_word(any_but(CH_BLANK), 1'b0);
  endtask

  // Feed a character that is no hex digit, or the end of text
  task automatic send_bad_digit();
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      send_word(8'($urandom_range(255)), 1'b1);
    end else begin
      do c = 8'($urandom_range(255)); while (frame_book::nibble_of(c) >= 0);
      send_word(c, 1'b0);
    end
  endtask

  task automatic set_pressure(input int unsigned phase);
    case (phase)
      0: begin src_idle_pct = 30; snk_stall_pct = 47; end
      1: begin src_idle_pct = 47; snk_stall_pct = 30; end
      default: begin src_idle_pct = 0; snk_stall_pct = 0; end
    endcase
  endtask

  initial begin
    logic [15:0] len;
    int unsigned count;
    int unsigned sel;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: end of text in label, minus and field modes
    send_word(8'h00, 1'b1);
    send_word("z", 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word("z", 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(CH_MINUS, 1'b0);
    send_word("q", 1'b0);
    send_word(8'h00, 1'b1);
    // Directed: shortest good record, extreme bytes, closed by end of text
    send_word(8'hFF, 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_word(CH_MINUS, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(CH_BLANK, 1'b0);
    send_byte(8'hFF);
    send_word(CH_BLANK, 1'b0);
    send_byte(8'h00);
    send_word(CH_BLANK, 1'b0);
    send_byte(8'h00);
    send_word(CH_BLANK, 1'b0);
    send_byte(8'h00);
    send_word(8'h00, 1'b1);

    // Random: mostly good records, some truncated openings
    body_words = 0;
    while (body_words < BODY_TARGET) begin
      set_pressure(body_words * 3 / BODY_TARGET);
      sel = $urandom_range(9);
      if (sel < 8) begin
        len = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 40))
                                       : 16'($urandom_range(0, 12));
        send_frame(len + 4, len, $urandom_range(3) == 0);
      end else if (sel == 8) begin
        send_label();
        send_word(8'($urandom_range(255)), 1'b1);
      end else begin
        send_label();
        send_word(CH_BLANK, 1'b0);
        if ($urandom_range(1)) begin
          send_word(CH_MINUS, 1'b0);
          repeat ($urandom_range(0, 3)) send_word(any_but(CH_BLANK), 1'b0);
        end
        send_word(8'($urandom_range(255)), 1'b1);
      end
    end

    // Close with one record kind; any fault halts the parser for good
    closing_st = 3'($urandom_range(ST_LEN_ERR, ST_OK));
    case (closing_st)
      ST_NO_MINUS: begin
        send_label();
        send_word(CH_BLANK, 1'b0);
        send_word(any_but(CH_MINUS), 1'b0);
      end
      ST_BAD_HIGH: begin
        send_head();
        count = $urandom_range(0, 3);
        send_bytes(count, 16'($urandom));
        if (count != 0) send_word(CH_BLANK, 1'b0);
        send_bad_digit();
      end
      ST_BAD_LOW: begin
        send_head();
        count = $urandom_range(0, 3);
        send_bytes(count, 16'($urandom));
        if (count != 0) send_word(CH_BLANK, 1'b0);
        send_word(hex_char(4'($urandom_range(15))), 1'b0);
        send_bad_digit();
      end
      ST_LEN_ERR: begin
        count = $urandom_range(1, 8);
        len = 16'($urandom);
        if (count >= 4 && {1'b0, len} + LEN_BIAS == count) len = len + 16'd1;
        send_frame(count, len, $urandom_range(1) == 0);
      end
      default: begin
        send_frame(4, 16'h0000, 1'b0);
      end
    endcase
    // Trailing words: nothing may come out after a fault
    repeat (8) send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
    s_axis_tvalid <= 1'b0;

    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run fed %0d text words and checked %0d output words, %0d good frames.",
             book.n_words_in, book.n_words_out, book.n_frames);
    $display("Closing record kind: status %0d (0 = well formed).", closing_st);
    if (book.n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("Timeout: %0d output words still expected", book.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
